>>> rtl/core/ppmenc_pkg.sv
// ----------------------------------------------------------------------------
// ppmenc_pkg
// Shared constants, register indexes and types of the PPM frame encoder.
// ----------------------------------------------------------------------------
package ppmenc_pkg;

    // channel store geometry
    localparam int CHANNELS = 8;
    localparam int CH_W     = $clog2(CHANNELS);
    localparam int SEGMENTS = 2 * CHANNELS + 2;

    // field widths
    localparam int SAMPLE_W = 12;
    localparam int SEG_W    = 5;
    localparam int SLOT_W   = 11;
    localparam int PERIOD_W = 16;
    localparam int GAP_W    = 10;
    localparam int MASK_W   = 8;
    localparam int SUM_W    = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // last segment of a frame: high sync
    localparam logic [SEG_W-1:0] SEG_SYNC = SEG_W'(SEGMENTS - 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP          = 2'd2;

    // register reset values
    localparam logic [MASK_W-1:0]   RESET_REVERSE_MASK = 8'd6;
    localparam logic [PERIOD_W-1:0] RESET_FRAME_PERIOD = 16'd20000;
    localparam logic [GAP_W-1:0]    RESET_GAP          = 10'd500;

    // sample store reset: centre stick on the lower channels, zero above
    localparam int                   RESET_CENTRE_CHANNELS = 4;
    localparam logic [SAMPLE_W-1:0]  RESET_SAMPLE_CENTRE   = 12'd2048;
    localparam logic [SAMPLE_W-1:0]  RESET_SAMPLE_OTHER    = 12'd0;

    // slot mapping constants
    localparam logic [SAMPLE_W-1:0] SAMPLE_MID = 12'd2047;
    localparam logic [SLOT_W:0]     SLOT_BASE_LO = 12'd1000;
    localparam logic [SLOT_W:0]     SLOT_BASE_HI = 12'd1500;
    localparam logic [SLOT_W:0]     SLOT_MIRROR  = 12'd3000;

    // one result word
    typedef struct packed {
        logic             ppm_level;
        logic [SEG_W-1:0] segment_index;
        logic             frame_start;
    } result_t;

endpackage

>>> rtl/core/ppm_frame_encoder.sv
// ----------------------------------------------------------------------------
// ppm_frame_encoder
// Radio-control PPM frame generator: sample writes fill an eight-entry store,
// microsecond ticks walk through gap, pulse and sync segments.
// ----------------------------------------------------------------------------
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------------------
//  input     | s_valid / s_ready     | s_mode, s_channel, s_sample
//  result    | m_valid / m_ready     | m_ppm_level, m_segment_index, m_frame_start
//  config    | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One word per cycle is accepted while s_ready is high; its result is registered.
//  The sample store is read every cycle at the channel of the next pulse, so
//  the slot is ready when the pulse starts; a same-cycle write to it is forwarded.
//  Reset clears control state and the store's valid bits; no clearing pass.
//  An output register plus one skid word: s_ready falls only when both are full.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module ppm_frame_encoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input words
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic [2:0]                        s_channel,
    input  logic [ppmenc_pkg::SAMPLE_W-1:0]   s_sample,
    // result words
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_ppm_level,
    output logic [ppmenc_pkg::SEG_W-1:0]      m_segment_index,
    output logic                              m_frame_start,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ppmenc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppmenc_pkg::CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [ppmenc_pkg::MASK_W-1:0]   reverse_mask_reg;
    logic [ppmenc_pkg::PERIOD_W-1:0] frame_period_reg;
    logic [ppmenc_pkg::GAP_W-1:0]    gap_reg;

    // frame state
    logic [ppmenc_pkg::SEG_W-1:0]    seg_reg, seg_next;
    logic [ppmenc_pkg::PERIOD_W-1:0] elapsed_reg, elapsed_next;
    logic [ppmenc_pkg::PERIOD_W-1:0] seg_len_reg, seg_len_next;
    logic [ppmenc_pkg::SUM_W-1:0]    slot_sum_reg, slot_sum_next;
    logic                            level_reg, level_next;

    // store access
    logic                              accept;
    logic                              tick;
    logic                              wr_en;
    logic [ppmenc_pkg::CH_W-1:0]       wr_addr;
    logic [ppmenc_pkg::CH_W-1:0]       rd_addr;
    logic [ppmenc_pkg::CH_W-1:0]       rd_addr_reg;
    logic [ppmenc_pkg::SAMPLE_W-1:0]   ram_q;
    logic [ppmenc_pkg::CHANNELS-1:0]   valid_reg;
    logic                              rd_valid_reg;
    logic                              byp_hit_reg;
    logic [ppmenc_pkg::SAMPLE_W-1:0]   byp_data_reg;
    logic [ppmenc_pkg::SAMPLE_W-1:0]   cur_sample;
    logic [ppmenc_pkg::SLOT_W-1:0]     cur_slot;

    // segment step
    logic [ppmenc_pkg::PERIOD_W-1:0] elapsed_inc;
    logic                            advance;
    logic [ppmenc_pkg::SEG_W-1:0]    seg_new;
    logic signed [ppmenc_pkg::PERIOD_W+1:0] sync_diff;
    logic signed [ppmenc_pkg::SLOT_W+1:0]   pulse_diff;

    // output staging
    ppmenc_pkg::result_t res;
    ppmenc_pkg::result_t out_reg, skid_reg;
    logic                out_valid_reg, skid_valid_reg;
    logic                out_free;

    assign accept    = s_valid && s_ready;
    assign tick      = accept && s_mode;
    assign wr_en     = accept && !s_mode &&
                       ({1'b0, s_channel} < 4'(ppmenc_pkg::CHANNELS));
    assign wr_addr   = s_channel[ppmenc_pkg::CH_W-1:0];
    assign cfg_ready = 1'b1;

    // configuration write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reverse_mask_reg <= ppmenc_pkg::RESET_REVERSE_MASK;
            frame_period_reg <= ppmenc_pkg::RESET_FRAME_PERIOD;
            gap_reg          <= ppmenc_pkg::RESET_GAP;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ppmenc_pkg::REG_REVERSE_MASK:
                    reverse_mask_reg <= cfg_data[ppmenc_pkg::MASK_W-1:0];
                ppmenc_pkg::REG_FRAME_PERIOD:
                    frame_period_reg <= cfg_data[ppmenc_pkg::PERIOD_W-1:0];
                ppmenc_pkg::REG_GAP:
                    gap_reg <= cfg_data[ppmenc_pkg::GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // sample store, read at the channel of the next pulse
    assign rd_addr = seg_next[ppmenc_pkg::CH_W:1];

    ppmenc_ram #(
        .WIDTH (ppmenc_pkg::SAMPLE_W),
        .DEPTH (ppmenc_pkg::CHANNELS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_sample),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // per-entry valid bits; a never-written entry reads as its reset value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // read side tracking and write forwarding
    always_ff @(posedge aclk) begin
        rd_addr_reg  <= rd_addr;
        rd_valid_reg <= valid_reg[rd_addr];
        byp_hit_reg  <= wr_en && (wr_addr == rd_addr);
        byp_data_reg <= s_sample;
    end

    always_comb begin
        if (byp_hit_reg) begin
            cur_sample = byp_data_reg;
        end else if (rd_valid_reg) begin
            cur_sample = ram_q;
        end else if (32'(rd_addr_reg) < ppmenc_pkg::RESET_CENTRE_CHANNELS) begin
            cur_sample = ppmenc_pkg::RESET_SAMPLE_CENTRE;
        end else begin
            cur_sample = ppmenc_pkg::RESET_SAMPLE_OTHER;
        end
    end

    ppmenc_slot_map u_slot_map (
        .sample  (cur_sample),
        .reverse (reverse_mask_reg[rd_addr_reg]),
        .slot    (cur_slot)
    );

    // segment timing and length latch
    assign elapsed_inc = elapsed_reg + 1'b1;
    assign advance     = (elapsed_inc >= seg_len_reg) || (elapsed_inc == '0);
    assign seg_new     = (seg_reg == ppmenc_pkg::SEG_SYNC) ? '0 : seg_reg + 1'b1;
    assign sync_diff   = $signed({2'b00, frame_period_reg})
                       - $signed({3'b000, slot_sum_reg});
    assign pulse_diff  = $signed({2'b00, cur_slot})
                       - $signed({3'b000, gap_reg});

    always_comb begin
        seg_next      = seg_reg;
        elapsed_next  = elapsed_reg;
        seg_len_next  = seg_len_reg;
        slot_sum_next = slot_sum_reg;
        level_next    = level_reg;
        if (tick) begin
            elapsed_next = elapsed_inc;
            if (advance) begin
                elapsed_next = '0;
                seg_next     = seg_new;
                level_next   = seg_new[0];
                if (seg_new == '0) begin
                    slot_sum_next = '0;
                end
                if (seg_new == ppmenc_pkg::SEG_SYNC) begin
                    // sync lasts the frame period less the summed slots, at least one tick
                    if (sync_diff <= 0) begin
                        seg_len_next = 16'd1;
                    end else begin
                        seg_len_next = sync_diff[ppmenc_pkg::PERIOD_W-1:0];
                    end
                end else if (seg_new[0]) begin
                    // channel pulse: slot minus the preceding gap
                    slot_sum_next = slot_sum_reg + ppmenc_pkg::SUM_W'(cur_slot);
                    if (pulse_diff <= 0) begin
                        seg_len_next = 16'd1;
                    end else begin
                        seg_len_next = 16'(pulse_diff[ppmenc_pkg::SLOT_W-1:0]);
                    end
                end else begin
                    if (gap_reg == '0) begin
                        seg_len_next = 16'd1;
                    end else begin
                        seg_len_next = 16'(gap_reg);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg      <= '0;
            elapsed_reg  <= '0;
            seg_len_reg  <= 16'(ppmenc_pkg::RESET_GAP);
            slot_sum_reg <= '0;
            level_reg    <= 1'b0;
        end else begin
            seg_reg      <= seg_next;
            elapsed_reg  <= elapsed_next;
            seg_len_reg  <= seg_len_next;
            slot_sum_reg <= slot_sum_next;
            level_reg    <= level_next;
        end
    end

    // result word: state before this word's update
    always_comb begin
        res.ppm_level     = level_reg;
        res.segment_index = seg_reg;
        res.frame_start   = s_mode && (seg_reg == '0) && (elapsed_reg == '0);
    end

    // output register with one skid word
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= accept;
            end else begin
                out_valid_reg  <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
                if (accept) begin
                    skid_reg <= res;
                end
            end else if (accept) begin
                out_reg <= res;
            end
        end else if (accept) begin
            skid_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_ppm_level     = out_reg.ppm_level;
    assign m_segment_index = out_reg.segment_index;
    assign m_frame_start   = out_reg.frame_start;

endmodule

>>> rtl/core/ppmenc_ram.sv
// ----------------------------------------------------------------------------
// ppmenc_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module ppmenc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, returns contents before a same-cycle write
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/core/ppmenc_slot_map.sv
// ----------------------------------------------------------------------------
// ppmenc_slot_map
// Maps a 12-bit stick sample to a 1000..2000 us slot, with optional mirror.
// ----------------------------------------------------------------------------
module ppmenc_slot_map (
    input  logic [ppmenc_pkg::SAMPLE_W-1:0] sample,
    input  logic                            reverse,
    output logic [ppmenc_pkg::SLOT_W-1:0]   slot
);

    logic                                 lower_half;
    logic [19:0]                          prod_lo;
    logic [8:0]                           hi_lo;
    logic [11:0]                          part_sum;
    logic [8:0]                           quot_lo;
    logic [ppmenc_pkg::SAMPLE_W-1:0]      diff_hi;
    logic [19:0]                          prod_hi;
    logic [ppmenc_pkg::SLOT_W:0]          slot_fwd;

    assign lower_half = (sample < ppmenc_pkg::SAMPLE_MID);

    // lower half: floor(s*500/2047); x = a*2048 + b gives q = a + ((a+b) >= 2047)
    assign prod_lo  = 20'(sample[10:0]) * 20'd500;
    assign hi_lo    = prod_lo[19:11];
    assign part_sum = 12'(hi_lo) + 12'(prod_lo[10:0]);
    assign quot_lo  = hi_lo + 9'(part_sum >= 12'(ppmenc_pkg::SAMPLE_MID));

    // upper half: floor((s-2047)*500/2048) is a shift
    assign diff_hi = sample - ppmenc_pkg::SAMPLE_MID;
    assign prod_hi = 20'(diff_hi) * 20'd500;

    // select half, then mirror about 1500 when reverse is set
    always_comb begin
        if (lower_half) begin
            slot_fwd = ppmenc_pkg::SLOT_BASE_LO + 12'(quot_lo);
        end else begin
            slot_fwd = ppmenc_pkg::SLOT_BASE_HI + 12'(prod_hi[19:11]);
        end
        if (reverse) begin
            slot = ppmenc_pkg::SLOT_W'(ppmenc_pkg::SLOT_MIRROR - slot_fwd);
        end else begin
            slot = ppmenc_pkg::SLOT_W'(slot_fwd);
        end
    end

endmodule

>>> rtl/core/ppmenc_checker.sv
// ----------------------------------------------------------------------------
// ppmenc_checker
// Port-level checks of the PPM frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
module ppmenc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic                              m_ppm_level,
    input logic [ppmenc_pkg::SEG_W-1:0]      m_segment_index,
    input logic                              m_frame_start
);

    // segment index stays inside the frame
    a_seg_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_segment_index <= ppmenc_pkg::SEG_SYNC))
        else $error("segment index beyond sync");

    // line is low in gaps and high in pulses and sync
    a_level_parity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_ppm_level == m_segment_index[0]))
        else $error("line level does not match segment kind");

    // a frame opens in the first gap
    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_start) |-> ((m_segment_index == '0) && !m_ppm_level))
        else $error("frame start outside the first gap");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_ppm_level)
            && $stable(m_segment_index) && $stable(m_frame_start)))
        else $error("stalled result word changed");

    // an accepted word with a free output shows up in the next cycle
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (!m_valid || m_ready)) |=> m_valid)
        else $error("accepted word produced no result");

endmodule

bind ppm_frame_encoder ppmenc_checker u_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_ppm_level     (m_ppm_level),
    .m_segment_index (m_segment_index),
    .m_frame_start   (m_frame_start)
);
